FILE: src/tgarle_pkg.sv
package tgarle_pkg;

   // Result kinds
   localparam logic [1:0] KIND_PIXEL      = 2'd0;
   localparam logic [1:0] KIND_HEADER_OK  = 2'd1;
   localparam logic [1:0] KIND_BAD_HEADER = 2'd2;
   localparam logic [1:0] KIND_BAD_SIZE   = 2'd3;

   // Header byte positions
   localparam logic [4:0] HDR_ID_LEN     = 5'd12;
   localparam logic [4:0] HDR_TYPE_POS   = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
   localparam logic [4:0] HDR_DEPTH_POS  = 5'd16;

   // Image types and pixel depths
   localparam logic [7:0] TYPE_RAW_TRUECOLOR = 8'd2;
   localparam logic [7:0] TYPE_RLE_TRUECOLOR = 8'd10;
   localparam logic [7:0] DEPTH_24           = 8'd24;
   localparam logic [7:0] DEPTH_32           = 8'd32;

   // Packet byte decoding
   localparam logic [7:0] RUN_BIAS   = 8'd127;
   localparam logic [7:0] ALPHA_FULL = 8'd255;
   localparam int         FLIP_BIT   = 5;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_HEADER = 2'd1,
      PH_PACKET = 2'd2,
      PH_PIXEL  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_res;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        top_first;
      logic        last;
   } rsp_type;

endpackage

FILE: src/tgarle_decoder.sv
module tgarle_decoder import tgarle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   output logic    res_valid,
   output rsp_type res
);

   phase_type   phase_ff, phase_in, ph;
   logic [4:0]  header_count_ff, header_count_in, hc;
   logic        is_compressed_ff, is_compressed_in;
   logic        is_deep_ff, is_deep_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] pixels_left_ff, pixels_left_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic        packet_is_run_ff, packet_is_run_in;
   logic [1:0]  channel_ff, channel_in;
   logic [23:0] gather_ff, gather_in;

   logic [7:0]  d;
   logic [1:0]  final_idx;
   logic [23:0] gather_v;
   logic [7:0]  alpha_v;
   logic [7:0]  rep_v;
   logic [31:0] left_v;
   logic [7:0]  pl_v;
   logic        id_ok;
   logic        size_ok;

   assign d         = req.data_byte;
   assign final_idx = is_deep_ff ? 2'd3 : 2'd2;

   // Hold state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         header_count_ff  <= '0;
         is_compressed_ff <= 1'b0;
         is_deep_ff       <= 1'b0;
         width_ff         <= '0;
         height_ff        <= '0;
         pixels_left_ff   <= '0;
         packet_left_ff   <= '0;
         packet_is_run_ff <= 1'b0;
         channel_ff       <= '0;
         gather_ff        <= '0;
      end else begin
         phase_ff         <= phase_in;
         header_count_ff  <= header_count_in;
         is_compressed_ff <= is_compressed_in;
         is_deep_ff       <= is_deep_in;
         width_ff         <= width_in;
         height_ff        <= height_in;
         pixels_left_ff   <= pixels_left_in;
         packet_left_ff   <= packet_left_in;
         packet_is_run_ff <= packet_is_run_in;
         channel_ff       <= channel_in;
         gather_ff        <= gather_in;
      end
   end

   // Decode one request byte: next state and result
   always_comb begin
      phase_in         = phase_ff;
      header_count_in  = header_count_ff;
      is_compressed_in = is_compressed_ff;
      is_deep_in       = is_deep_ff;
      width_in         = width_ff;
      height_in        = height_ff;
      pixels_left_in   = pixels_left_ff;
      packet_left_in   = packet_left_ff;
      packet_is_run_in = packet_is_run_ff;
      channel_in       = channel_ff;
      gather_in        = gather_ff;
      res_valid        = 1'b0;
      res              = '0;

      // a start byte restarts the header walk in any phase
      hc = req.start_req ? 5'd0 : header_count_ff;
      ph = req.start_req ? PH_HEADER : phase_ff;

      id_ok   = 1'b0;
      size_ok = 1'b0;
      gather_v = gather_ff;
      alpha_v  = ALPHA_FULL;
      rep_v    = 8'd1;
      left_v   = pixels_left_ff;
      pl_v     = packet_left_ff;

      if (step) begin
         phase_in        = ph;
         header_count_in = hc;
         case (ph)
            PH_HEADER: begin
               header_count_in = hc + 5'd1;
               if (hc < HDR_ID_LEN) begin
                  // check identification bytes
                  if (hc == HDR_TYPE_POS) begin
                     id_ok = (d == TYPE_RAW_TRUECOLOR) || (d == TYPE_RLE_TRUECOLOR);
                     is_compressed_in = (d == TYPE_RLE_TRUECOLOR);
                  end else begin
                     id_ok = (d == 8'd0);
                  end
                  if (!id_ok) begin
                     phase_in       = PH_IDLE;
                     res_valid      = 1'b1;
                     res.kind       = KIND_BAD_HEADER;
                     res.last       = 1'b1;
                  end
               end else begin
                  case (hc)
                     HDR_WIDTH_LO:  width_in  = {8'd0, d};
                     HDR_WIDTH_HI:  width_in  = {d, width_ff[7:0]};
                     HDR_HEIGHT_LO: height_in = {8'd0, d};
                     HDR_HEIGHT_HI: height_in = {d, height_ff[7:0]};
                     HDR_DEPTH_POS: gather_in = {16'd0, d};
                     default: begin
                        // descriptor byte: validate and open the image
                        size_ok = (width_ff != 16'd0) && (height_ff != 16'd0) &&
                                  ((gather_ff[7:0] == DEPTH_24) ||
                                   (gather_ff[7:0] == DEPTH_32));
                        res_valid        = 1'b1;
                        res.image_width  = width_ff;
                        res.image_height = height_ff;
                        res.top_first    = d[FLIP_BIT];
                        if (!size_ok) begin
                           phase_in = PH_IDLE;
                           res.kind = KIND_BAD_SIZE;
                           res.last = 1'b1;
                        end else begin
                           is_deep_in       = (gather_ff[7:0] == DEPTH_32);
                           pixels_left_in   = {16'd0, width_ff} * {16'd0, height_ff};
                           gather_in        = '0;
                           channel_in       = '0;
                           packet_left_in   = '0;
                           packet_is_run_in = 1'b0;
                           phase_in = is_compressed_ff ? PH_PACKET : PH_PIXEL;
                           res.kind = KIND_HEADER_OK;
                        end
                     end
                  endcase
               end
            end
            PH_PACKET: begin
               // start a raw packet or a run
               if (!d[7]) begin
                  packet_is_run_in = 1'b0;
                  packet_left_in   = {1'b0, d[6:0]} + 8'd1;
               end else begin
                  packet_is_run_in = 1'b1;
                  packet_left_in   = d - RUN_BIAS;
               end
               channel_in = '0;
               phase_in   = PH_PIXEL;
            end
            PH_PIXEL: begin
               // gather colour bytes
               case (channel_ff)
                  2'd0:    gather_v[7:0]   = d;
                  2'd1:    gather_v[15:8]  = d;
                  2'd2:    gather_v[23:16] = d;
                  default: gather_v        = gather_ff;
               endcase
               gather_in = gather_v;
               if (channel_ff < final_idx) begin
                  channel_in = channel_ff + 2'd1;
               end else begin
                  channel_in = '0;
                  alpha_v = is_deep_ff ? d : ALPHA_FULL;
                  // run packets emit one result, clipped to the image end
                  if (is_compressed_ff && packet_is_run_ff) begin
                     if ({24'd0, packet_left_ff} > pixels_left_ff) begin
                        rep_v = pixels_left_ff[7:0];
                     end else begin
                        rep_v = packet_left_ff;
                     end
                     pl_v = '0;
                  end else begin
                     rep_v = 8'd1;
                     if (packet_left_ff != 8'd0) begin
                        pl_v = packet_left_ff - 8'd1;
                     end
                  end
                  left_v         = pixels_left_ff - {24'd0, rep_v};
                  packet_left_in = pl_v;
                  pixels_left_in = left_v;
                  if (left_v == 32'd0) begin
                     phase_in = PH_IDLE;
                  end else if (is_compressed_ff && (pl_v == 8'd0)) begin
                     phase_in = PH_PACKET;
                  end
                  res_valid      = 1'b1;
                  res.kind       = KIND_PIXEL;
                  res.alpha      = alpha_v;
                  res.repeat_res = rep_v;
                  res.last       = (left_v == 32'd0);
                  if (alpha_v != 8'd0) begin
                     res.red   = gather_v[23:16];
                     res.green = gather_v[15:8];
                     res.blue  = gather_v[7:0];
                  end
               end
            end
            default: begin
               // idle: drop the byte
            end
         endcase
      end
   end

   // Assertions
   a_no_fourth_channel_24: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PIXEL && !is_deep_ff) |-> (channel_ff != 2'd3))
      else $error("fourth channel byte in 24-bit mode");

   a_pixels_owed: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PIXEL) |-> (pixels_left_ff != 32'd0))
      else $error("gathering pixel with no pixels left");

   a_header_opens_image: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_HEADER_OK) |=>
         (phase_ff == PH_PACKET || phase_ff == PH_PIXEL))
      else $error("accepted header did not open pixel data");

endmodule

FILE: src/tga_rle_stream_decoder_top.sv
// TGA truecolor stream decoder: feed the file one byte per request, with
// start_req set on its first byte. Identification (type 2 raw or type 10 RLE),
// size and depth are checked, then pixels come out with blue and red swapped,
// one result per pixel or per RLE run (repeat_res gives the run length). The
// block takes one byte every clock while req_stall is low; each accepted byte
// is decoded combinationally and its result is registered into the output stage
// (the width by height product at the descriptor byte is the longest path). A
// two-deep output stage lets input continue while a result waits; req_stall
// rises only when both output slots hold results.
module tga_rle_stream_decoder_top import tgarle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    step;
   logic    res_valid;
   rsp_type res;
   logic    take;

   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type skid_ff, skid_in;
   logic    skid_valid_ff, skid_valid_in;

   assign req_stall   = skid_valid_ff;
   assign step        = req_valid && !req_stall;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;
   assign take        = out_valid_ff && !rsp_stall;

   tgarle_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .req       (req_payload),
      .res_valid (res_valid),
      .res       (res)
   );

   // Advance the output register and skid slot
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // Assertions
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot full while output register empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid slot filled without a stalled output");

   a_skid_drains_to_out: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && take) |=> out_valid_ff)
      else $error("skid result lost on drain");

endmodule
